// File: design/ywa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ywa_pkg: shared types and codes of the YUYV window average probe
// Holds op codes, status codes, register indexes and the controller/datapath command and status structs.
// ----------------------------------------------------------------------------
package ywa_pkg;

  localparam logic [1:0] OP_FRAME = 2'd0;
  localparam logic [1:0] OP_DATA  = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_FRAME = 2'd1;
  localparam logic [1:0] ST_OUTSIDE  = 2'd2;

  localparam int REG_WIDTH  = 0;
  localparam int REG_HEIGHT = 1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_query;   // latch query fields and compute window bounds
    logic start_walk;   // set up the walk at the window's first pixel
    logic issue_read;   // compute address of current pixel and step
    logic accum;        // add the returned pixel into the sums
    logic start_div;    // begin the three divisions
    logic div_step;     // one restoring division step
  } ywa_cmd_t;

  // Status returned by the datapath.
  typedef struct packed {
    logic       walk_last;  // current pixel is the window's last one
    logic       div_done;   // all quotient bits produced
    logic [1:0] status;     // status of the latched query
    logic       single;     // radius zero query
  } ywa_sts_t;

endpackage

// File: design/ywa_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ywa_ram: generic single port RAM
// One write or one read per cycle; the read data is registered.
// ----------------------------------------------------------------------------
module ywa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 38400
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// File: design/ywa_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ywa_datapath: frame store, window walk, sums and dividers
// Writes frame words, walks a clipped window one pixel per cycle and divides
// the three sums by the pixel count one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ywa_datapath
  import ywa_pkg::*;
#(
  parameter int MAX_WIDTH  = 320,
  parameter int MAX_HEIGHT = 240,
  parameter int MAX_RADIUS = 255
) (
  input  logic        clk,
  input  logic        rst_n,
  input  ywa_cmd_t    cmd,
  input  logic        frame_begin,
  input  logic [11:0] hdr_width,
  input  logic [11:0] hdr_height,
  input  logic        format_is_yuv422,
  input  logic        data_we,
  input  logic [31:0] pair_word,
  input  logic [15:0] point_x,
  input  logic [15:0] point_y,
  input  logic [7:0]  radius,
  input  logic [8:0]  exp_width,
  input  logic [7:0]  exp_height,
  output ywa_sts_t    sts,
  output logic [7:0]  luma,
  output logic [7:0]  chroma_u,
  output logic [7:0]  chroma_v
);

  localparam int WORDS = (MAX_WIDTH * MAX_HEIGHT) / 2;
  localparam int AW    = $clog2(WORDS);
  localparam int WIW   = $clog2(WORDS + 1);
  localparam int RW    = $clog2(MAX_RADIUS + 1);
  localparam int PW    = $clog2(512 * 256);           // linear pixel index
  localparam int NW    = $clog2(512 * 256 + 1);        // pixel count
  localparam int SW    = NW + 8;                       // sum width
  localparam int DCW   = $clog2(SW + 1);

  // Frame bookkeeping.
  logic [WIW-1:0] wr_idx_r;
  logic           frame_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_idx_r      <= '0;
      frame_valid_r <= 1'b0;
    end else if (frame_begin) begin
      wr_idx_r      <= '0;
      frame_valid_r <= format_is_yuv422 && (hdr_width == {3'd0, exp_width})
                       && (hdr_height == {4'd0, exp_height});
    end else if (data_we && (wr_idx_r < WIW'(WORDS))) begin
      wr_idx_r <= wr_idx_r + 1'b1;
    end
  end

  // Query latch and window bounds.
  logic [1:0] status_r;
  logic       single_r;
  logic [8:0] x0_r, x1_r, xc_r;
  logic [7:0] y0_r, y1_r, yc_r;
  logic [8:0] cx_r;
  logic [7:0] cy_r;

  logic signed [16:0] sx, sy;
  logic [RW-1:0]      rad;
  logic [17:0]        lo_x, hi_x, lo_y, hi_y;

  always_comb begin
    sx  = {point_x[15], point_x};
    sy  = {point_y[15], point_y};
    rad = (32'(radius) > 32'(MAX_RADIUS)) ? RW'(MAX_RADIUS) : RW'(radius);
    lo_x = (18'(point_x) >= 18'(rad)) ? 18'(point_x) - 18'(rad) : 18'd0;
    lo_y = (18'(point_y) >= 18'(rad)) ? 18'(point_y) - 18'(rad) : 18'd0;
    hi_x = 18'(point_x) + 18'(rad);
    hi_y = 18'(point_y) + 18'(rad);
    if (hi_x > 18'(exp_width) - 18'd1)  hi_x = 18'(exp_width) - 18'd1;
    if (hi_y > 18'(exp_height) - 18'd1) hi_y = 18'(exp_height) - 18'd1;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_query) begin
      single_r <= (rad == '0);
      if (!frame_valid_r) begin
        status_r <= ST_NO_FRAME;
      end else if (sx < 0 || sx >= 17'(exp_width) || sy < 0
                   || sy >= 17'(exp_height)) begin
        status_r <= ST_OUTSIDE;
      end else begin
        status_r <= ST_OK;
      end
      cx_r <= point_x[8:0];
      cy_r <= point_y[7:0];
      x0_r <= lo_x[8:0];
      y0_r <= lo_y[7:0];
      x1_r <= hi_x[8:0];
      y1_r <= hi_y[7:0];
    end
  end

  // Walk: one pixel address per cycle; the pixel index takes one multiply.
  logic [PW-1:0] pix;
  logic [8:0]    ax;
  logic [7:0]    ay;
  logic          pend_odd_r, pend_ok_r, acc_v_r;

  assign ax = single_r ? cx_r : xc_r;
  assign ay = single_r ? cy_r : yc_r;
  assign pix = PW'(ay) * PW'(exp_width) + PW'(ax);
  assign sts.walk_last = single_r || (xc_r == x1_r && yc_r == y1_r);
  assign sts.status = status_r;
  assign sts.single = single_r;

  always_ff @(posedge clk) begin
    if (cmd.start_walk) begin
      xc_r <= x0_r;
      yc_r <= y0_r;
    end else if (cmd.issue_read) begin
      if (xc_r == x1_r) begin
        xc_r <= x0_r;
        yc_r <= yc_r + 1'b1;
      end else begin
        xc_r <= xc_r + 1'b1;
      end
    end
    pend_odd_r <= pix[0];
    pend_ok_r  <= (32'(pix[PW-1:1]) < 32'(WORDS));
  end

  logic [AW-1:0] ram_addr;
  logic [31:0]   ram_q;
  logic [31:0]   word;

  assign ram_addr = data_we ? wr_idx_r[AW-1:0] : AW'(pix[PW-1:1]);

  ywa_ram #(.WIDTH(32), .DEPTH(WORDS)) u_ram (
    .clk   (clk),
    .we    (data_we && (wr_idx_r < WIW'(WORDS))),
    .addr  (ram_addr),
    .wdata (pair_word),
    .rdata (ram_q)
  );

  assign word = pend_ok_r ? ram_q : 32'd0;

  // Sums and count.
  logic [SW-1:0] sum_y_r, sum_u_r, sum_v_r;
  logic [NW-1:0] cnt_r;
  logic [7:0]    pix_y_r, pix_u_r, pix_v_r;

  always_ff @(posedge clk) begin
    if (cmd.start_walk) begin
      sum_y_r <= '0;
      sum_u_r <= '0;
      sum_v_r <= '0;
      cnt_r   <= '0;
    end else if (cmd.accum) begin
      pix_y_r <= pend_odd_r ? word[23:16] : word[7:0];
      pix_u_r <= word[15:8];
      pix_v_r <= word[31:24];
      sum_y_r <= sum_y_r + SW'(pend_odd_r ? word[23:16] : word[7:0]);
      sum_u_r <= sum_u_r + SW'(word[15:8]);
      sum_v_r <= sum_v_r + SW'(word[31:24]);
      cnt_r   <= cnt_r + 1'b1;
    end
  end

  // Restoring dividers, one quotient bit per cycle for all three sums.
  logic [SW-1:0]  qy_r, qu_r, qv_r;
  logic [NW:0]    ry_r, ru_r, rv_r;
  logic [DCW-1:0] dcnt_r;
  logic [NW:0]    ty, tu, tv;

  assign ty = {ry_r[NW-1:0], qy_r[SW-1]};
  assign tu = {ru_r[NW-1:0], qu_r[SW-1]};
  assign tv = {rv_r[NW-1:0], qv_r[SW-1]};
  assign sts.div_done = (dcnt_r == '0);

  always_ff @(posedge clk) begin
    if (cmd.start_div) begin
      qy_r <= sum_y_r;
      qu_r <= sum_u_r;
      qv_r <= sum_v_r;
      ry_r <= '0;
      ru_r <= '0;
      rv_r <= '0;
      dcnt_r <= DCW'(SW);
    end else if (cmd.div_step) begin
      ry_r <= (ty >= {1'b0, cnt_r}) ? ty - {1'b0, cnt_r} : ty;
      ru_r <= (tu >= {1'b0, cnt_r}) ? tu - {1'b0, cnt_r} : tu;
      rv_r <= (tv >= {1'b0, cnt_r}) ? tv - {1'b0, cnt_r} : tv;
      qy_r <= {qy_r[SW-2:0], ty >= {1'b0, cnt_r}};
      qu_r <= {qu_r[SW-2:0], tu >= {1'b0, cnt_r}};
      qv_r <= {qv_r[SW-2:0], tv >= {1'b0, cnt_r}};
      dcnt_r <= dcnt_r - 1'b1;
    end
  end

  always_comb begin
    if (status_r != ST_OK) begin
      luma = 8'd0; chroma_u = 8'd0; chroma_v = 8'd0;
    end else if (single_r) begin
      luma = pix_y_r; chroma_u = pix_u_r; chroma_v = pix_v_r;
    end else begin
      luma = qy_r[7:0]; chroma_u = qu_r[7:0]; chroma_v = qv_r[7:0];
    end
  end

endmodule

// File: design/ywa_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ywa_ctrl: sequencer of the window average probe
// Accepts items, runs a query through walk and division, holds the result.
// ----------------------------------------------------------------------------
module ywa_ctrl
  import ywa_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic [1:0] in_op,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  ywa_sts_t sts,
  output ywa_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE, S_CHECK, S_WALK, S_DRAIN, S_DIVINIT, S_DIV, S_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   take;

  // Pipelined accumulation: the read issued in one walk cycle returns next.
  logic walk_d_r;

  assign in_ready  = (state_r == S_IDLE);
  assign take      = in_valid && in_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    case (state_r)
      S_IDLE: begin
        if (take && in_op == OP_QUERY) begin
          cmd.load_query = 1'b1;
          state_nxt      = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.start_walk = 1'b1;
        if (sts.status != ST_OK) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_OUT;
        end else begin
          state_nxt = S_WALK;
        end
      end
      S_WALK: begin
        cmd.issue_read = 1'b1;
        // Accumulate each word the cycle after its read was issued.
        cmd.accum      = walk_d_r;
        if (sts.walk_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        // Last read word is now on the RAM output.
        cmd.accum = 1'b1;
        if (sts.single) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_OUT;
        end else begin
          state_nxt = S_DIVINIT;
        end
      end
      S_DIVINIT: begin
        // The sums are final here, so the dividers load them.
        cmd.start_div = 1'b1;
        state_nxt     = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) begin
          cmd.div_step  = 1'b0;
          out_valid_nxt = 1'b1;
          state_nxt     = S_OUT;
        end
      end
      S_OUT: begin
        if (out_ready) begin
          out_valid_nxt = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      walk_d_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      walk_d_r    <= (state_r == S_WALK) && !sts.walk_last;
    end
  end

  property p_out_hold;
    @(posedge clk) disable iff (!rst_n) out_valid && !out_ready |=> out_valid;
  endproperty
  a_out_hold: assert property (p_out_hold) else $error("result dropped");

  a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("item taken while result pending");

  a_walk_exits: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DRAIN |=> state_r == S_DIVINIT || state_r == S_OUT)
    else $error("drain did not move on");

  a_drain_after_walk: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DRAIN |-> $past(state_r == S_WALK))
    else $error("drain without walk");

endmodule

// File: design/yuyv_window_average_probe_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yuyv_window_average_probe_unit: YUYV frame store with window average query
// Top level joining the sequencer and the datapath.
// ----------------------------------------------------------------------------
// Usage: items enter on the in_ stream. Frame-begin and data items give no
// result and leave the block ready for the next item; a data item writes one
// pixel-pair word into the frame store while it is not full. A query item
// gives one result on the out_ stream. A query walks its clipped window one
// pixel per cycle through the single store port. Its result follows the walk,
// a drain of the last read and a restoring division of the three sums. A
// radius zero query skips the division, and a query with error status skips
// the walk as well. While a query runs, and while a result waits for
// out_tready, the block takes no new item. Reset clears the write pointer and
// frame-valid flag and loads the size registers with 320 by 240; the store is
// not cleared. Configuration writes on cfg_ are taken in any cycle and should
// be issued only while no query is in flight.
// ----------------------------------------------------------------------------
module yuyv_window_average_probe_unit
  import ywa_pkg::*;
#(
  parameter int MAX_WIDTH  = 320,
  parameter int MAX_HEIGHT = 240,
  parameter int MAX_RADIUS = 255
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // tdata: hdr_width[11:0], hdr_height[23:12], format_is_yuv422[24],
  // pair_word[56:25], point_x[72:57], point_y[88:73], radius[96:89], zero fill
  input  logic [103:0] in_tdata,
  // tuser: op[1:0]
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // tdata: luma[7:0], chroma_u[15:8], chroma_v[23:16]
  output logic [23:0] out_tdata,
  // tuser: status[1:0]
  output logic [1:0]  out_tuser,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [8:0]  cfg_data
);

  logic [8:0] exp_width_r;
  logic [7:0] exp_height_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_width_r  <= 9'd320;
      exp_height_r <= 8'd240;
    end else if (cfg_valid) begin
      if (cfg_index == 1'(REG_WIDTH)) exp_width_r <= cfg_data;
      else                            exp_height_r <= cfg_data[7:0];
    end
  end

  ywa_cmd_t cmd;
  ywa_sts_t sts;
  logic     take;

  assign take = in_tvalid && in_tready;

  ywa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_op     (in_tuser),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ywa_datapath #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .MAX_RADIUS(MAX_RADIUS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .frame_begin      (take && in_tuser == OP_FRAME),
    .hdr_width        (in_tdata[11:0]),
    .hdr_height       (in_tdata[23:12]),
    .format_is_yuv422 (in_tdata[24]),
    .data_we          (take && in_tuser == OP_DATA),
    .pair_word        (in_tdata[56:25]),
    .point_x          (in_tdata[72:57]),
    .point_y          (in_tdata[88:73]),
    .radius           (in_tdata[96:89]),
    .exp_width        (exp_width_r),
    .exp_height       (exp_height_r),
    .sts              (sts),
    .luma             (out_tdata[7:0]),
    .chroma_u         (out_tdata[15:8]),
    .chroma_v         (out_tdata[23:16])
  );

  assign out_tuser = sts.status;

endmodule
